/* hdl/ppid_pkg.sv */
// Package for the positional PID controller.
// Holds the data widths, register indexes and the saturation helpers.
// No dependencies.
package ppid_pkg;

    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;
    localparam int TOL_W = DATA_W - 1;
    localparam int PROD_W = 2 * DATA_W;
    localparam int QUOT_W = DATA_W + FRAC_W;
    localparam int IDX_W = 4;

    typedef logic signed [DATA_W-1:0] sdata_t;
    typedef logic [DATA_W-1:0] udata_t;

    typedef enum logic [IDX_W-1:0] {
        REG_GAIN_P    = 4'd0,
        REG_GAIN_I    = 4'd1,
        REG_GAIN_D    = 4'd2,
        REG_TOLERANCE = 4'd3,
        REG_DRIVE_MIN = 4'd4,
        REG_DRIVE_MAX = 4'd5,
        REG_ACCUM_MIN = 4'd6,
        REG_ACCUM_MAX = 4'd7
    } reg_index_t;

    // Saturates a magnitude to the signed range and applies the sign.
    function automatic sdata_t sat_mag(input logic neg, input logic [PROD_W-1:0] m);
        logic [PROD_W-1:0] lim;
        udata_t r;
        lim = neg ? (PROD_W'(1) << (DATA_W - 1)) : ((PROD_W'(1) << (DATA_W - 1)) - PROD_W'(1));
        r = (m > lim) ? lim[DATA_W-1:0] : m[DATA_W-1:0];
        return neg ? sdata_t'(-r) : sdata_t'(r);
    endfunction

    function automatic udata_t mag(input sdata_t x);
        return x[DATA_W-1] ? udata_t'(-x) : udata_t'(x);
    endfunction

    function automatic sdata_t clamp(input sdata_t v, input sdata_t lo, input sdata_t hi);
        if (v < lo) begin
            return lo;
        end else if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

endpackage

/* hdl/ppid_serial_mul.sv */
// Bit-serial fixed-point multiplier, one multiplier bit per cycle.
// Produces the saturated signed product shifted by the fraction width.
// Depends on ppid_pkg.
module ppid_serial_mul (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic             neg,
    input  ppid_pkg::udata_t a,
    input  ppid_pkg::udata_t b,
    output logic             done,
    output ppid_pkg::sdata_t result
);
    import ppid_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    udata_t            a_reg, a_next;
    logic [PROD_W-1:0] p_reg, p_next;
    logic              neg_reg, neg_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DATA_W:0]   partial;

    always_comb begin
        a_next = a_reg;
        p_next = p_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        partial = {1'b0, p_reg[PROD_W-1:DATA_W]} + (p_reg[0] ? {1'b0, a_reg} : '0);
        if (start) begin
            a_next = a;
            p_next = {{DATA_W{1'b0}}, b};
            neg_next = neg;
            cnt_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            p_next = {partial, p_reg[DATA_W-1:1]};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DATA_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        a_reg <= a_next;
        p_reg <= p_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign result = sat_mag(neg_reg, p_reg >> FRAC_W);

endmodule

/* hdl/ppid_serial_div.sv */
// Restoring bit-serial divider, one quotient bit per cycle.
// Forms (n << FRAC_W) / d on magnitudes and saturates the signed result.
// Depends on ppid_pkg.
module ppid_serial_div (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic             neg,
    input  ppid_pkg::udata_t n,
    input  ppid_pkg::udata_t d,
    output logic             done,
    output ppid_pkg::sdata_t result
);
    import ppid_pkg::*;

    localparam int CNT_W = $clog2(QUOT_W);

    udata_t            d_reg, d_next;
    udata_t            rem_reg, rem_next;
    logic [QUOT_W-1:0] q_reg, q_next;
    logic              neg_reg, neg_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DATA_W:0]   trial;
    logic              ge;

    always_comb begin
        d_next = d_reg;
        rem_next = rem_reg;
        q_next = q_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {rem_reg, q_reg[QUOT_W-1]};
        ge = trial >= {1'b0, d_reg};
        if (start) begin
            d_next = d;
            rem_next = '0;
            q_next = {n, {FRAC_W{1'b0}}};
            neg_next = neg;
            cnt_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? DATA_W'(trial - {1'b0, d_reg}) : trial[DATA_W-1:0];
            q_next = {q_reg[QUOT_W-2:0], ge};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(QUOT_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        d_reg <= d_next;
        rem_reg <= rem_next;
        q_reg <= q_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign result = sat_mag(neg_reg, {{(PROD_W - QUOT_W){1'b0}}, q_reg});

endmodule

/* hdl/positional_pid_controller.sv */
// Positional PID controller with integral clamp, Q16.16 fixed point.
// Input channel s_*: target, measured value and step time, one item each.
// Result channel m_*: drive, reached flag, integral and error of that item.
// The block works on one item at a time. Two bit-serial multipliers and a
// bit-serial divider run side by side (the division sets the end of the first
// phase), then the two multipliers run again for the integral and derivative
// terms; the start, accumulate and output states sequence the phases. The next
// item is taken once the result is loaded into the output register, so a stalled
// receiver holds one finished result while the block already works on the next
// item; that item then waits for the output register to free up. Reset clears
// the integral and previous error, sets gains and tolerance to zero and the
// clamps to minus and plus one.
// The configuration port writes one register per cycle when cfg_we is high;
// unknown indexes are ignored. Write it only while the block is idle.
// Depends on ppid_pkg, ppid_serial_mul and ppid_serial_div.
module positional_pid_controller (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [ppid_pkg::IDX_W-1:0] cfg_index,
    input  ppid_pkg::udata_t          cfg_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  ppid_pkg::sdata_t          s_target,
    input  ppid_pkg::sdata_t          s_measured_value,
    input  ppid_pkg::udata_t          s_step_time,
    output logic                      m_valid,
    input  logic                      m_ready,
    output ppid_pkg::sdata_t          m_drive,
    output logic                      m_reached,
    output ppid_pkg::sdata_t          m_accum_now,
    output ppid_pkg::sdata_t          m_error_now
);
    import ppid_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_START1 = 7'b0000010,
        ST_PH1    = 7'b0000100,
        ST_ACC    = 7'b0001000,
        ST_START2 = 7'b0010000,
        ST_PH2    = 7'b0100000,
        ST_OUT    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    sdata_t gain_p_reg, gain_i_reg, gain_d_reg;
    logic [TOL_W-1:0] tol_reg;
    sdata_t drive_min_reg, drive_max_reg, accum_min_reg, accum_max_reg;
    sdata_t last_err_reg, accum_reg;

    sdata_t err_reg, err_next;
    udata_t dt_reg, dt_next;
    sdata_t acc_reg, acc_next;
    sdata_t der_reg, der_next;
    sdata_t pterm_reg, pterm_next;
    sdata_t drive_reg, drive_next;
    logic   m_valid_reg, m_valid_next;
    sdata_t m_drive_reg, m_acc_reg, m_err_reg;
    logic   m_reached_reg;

    logic             mul_start, div_start;
    logic             mul0_neg, mul1_neg;
    udata_t           mul0_a, mul0_b, mul1_a, mul1_b;
    logic             mul0_done, mul1_done, div_done;
    sdata_t           mul0_res, mul1_res, div_res;
    logic [DATA_W:0]  in_diff, der_diff, acc_sum;
    logic [DATA_W+1:0] drive_sum;
    sdata_t           err_sat, acc_sat, drive_sat;
    logic             out_free;

    ppid_serial_mul u_mul0 (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start), .neg(mul0_neg),
        .a(mul0_a), .b(mul0_b), .done(mul0_done), .result(mul0_res)
    );

    ppid_serial_mul u_mul1 (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start), .neg(mul1_neg),
        .a(mul1_a), .b(mul1_b), .done(mul1_done), .result(mul1_res)
    );

    ppid_serial_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .neg(der_diff[DATA_W]),
        .n(der_diff[DATA_W] ? DATA_W'(-der_diff) : der_diff[DATA_W-1:0]),
        .d(dt_reg), .done(div_done), .result(div_res)
    );

    assign in_diff = {s_target[DATA_W-1], s_target}
                   - {s_measured_value[DATA_W-1], s_measured_value};
    assign der_diff = {err_reg[DATA_W-1], err_reg} - {last_err_reg[DATA_W-1], last_err_reg};
    assign acc_sum = {accum_reg[DATA_W-1], accum_reg} + {mul0_res[DATA_W-1], mul0_res};
    assign drive_sum = {{2{pterm_reg[DATA_W-1]}}, pterm_reg}
                     + {{2{mul0_res[DATA_W-1]}}, mul0_res}
                     + {{2{mul1_res[DATA_W-1]}}, mul1_res};

    always_comb begin
        if (in_diff[DATA_W] != in_diff[DATA_W-1]) begin
            err_sat = in_diff[DATA_W] ? sdata_t'(PROD_W'(1) << (DATA_W - 1))
                                      : sdata_t'((PROD_W'(1) << (DATA_W - 1)) - PROD_W'(1));
        end else begin
            err_sat = in_diff[DATA_W-1:0];
        end
        if (acc_sum[DATA_W] != acc_sum[DATA_W-1]) begin
            acc_sat = acc_sum[DATA_W] ? sdata_t'(PROD_W'(1) << (DATA_W - 1))
                                      : sdata_t'((PROD_W'(1) << (DATA_W - 1)) - PROD_W'(1));
        end else begin
            acc_sat = acc_sum[DATA_W-1:0];
        end
        if (drive_sum[DATA_W+1:DATA_W-1] != {3{drive_sum[DATA_W+1]}}) begin
            drive_sat = drive_sum[DATA_W+1] ? sdata_t'(PROD_W'(1) << (DATA_W - 1))
                                            : sdata_t'((PROD_W'(1) << (DATA_W - 1)) - PROD_W'(1));
        end else begin
            drive_sat = drive_sum[DATA_W-1:0];
        end
    end

    always_comb begin
        mul_start = (state_reg == ST_START1) || (state_reg == ST_START2);
        div_start = (state_reg == ST_START1);
        if (state_reg == ST_START1) begin
            mul0_a = mag(err_reg);
            mul0_b = dt_reg;
            mul0_neg = err_reg[DATA_W-1];
            mul1_a = mag(gain_p_reg);
            mul1_b = mag(err_reg);
            mul1_neg = gain_p_reg[DATA_W-1] ^ err_reg[DATA_W-1];
        end else begin
            mul0_a = mag(gain_i_reg);
            mul0_b = mag(acc_reg);
            mul0_neg = gain_i_reg[DATA_W-1] ^ acc_reg[DATA_W-1];
            mul1_a = mag(gain_d_reg);
            mul1_b = mag(der_reg);
            mul1_neg = gain_d_reg[DATA_W-1] ^ der_reg[DATA_W-1];
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        err_next = err_reg;
        dt_next = dt_reg;
        acc_next = acc_reg;
        der_next = der_reg;
        pterm_next = pterm_reg;
        drive_next = drive_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    err_next = err_sat;
                    dt_next = s_step_time;
                    state_next = ST_START1;
                end
            end
            ST_START1: begin
                state_next = ST_PH1;
            end
            ST_PH1: begin
                if (div_done) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                acc_next = clamp(acc_sat, accum_min_reg, accum_max_reg);
                der_next = (dt_reg != '0) ? div_res : '0;
                pterm_next = mul1_res;
                state_next = ST_START2;
            end
            ST_START2: begin
                state_next = ST_PH2;
            end
            ST_PH2: begin
                if (mul1_done) begin
                    drive_next = clamp(drive_sat, drive_min_reg, drive_max_reg);
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        err_reg <= err_next;
        dt_reg <= dt_next;
        acc_reg <= acc_next;
        der_reg <= der_next;
        pterm_reg <= pterm_next;
        drive_reg <= drive_next;
        if (state_reg == ST_OUT && out_free) begin
            m_drive_reg <= drive_reg;
            m_acc_reg <= acc_reg;
            m_err_reg <= err_reg;
            m_reached_reg <= mag(err_reg) < {1'b0, tol_reg};
        end
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            m_valid_reg <= 1'b0;
            gain_p_reg <= '0;
            gain_i_reg <= '0;
            gain_d_reg <= '0;
            tol_reg <= '0;
            drive_min_reg <= sdata_t'(-(PROD_W'(1) << FRAC_W));
            drive_max_reg <= sdata_t'(PROD_W'(1) << FRAC_W);
            accum_min_reg <= sdata_t'(-(PROD_W'(1) << FRAC_W));
            accum_max_reg <= sdata_t'(PROD_W'(1) << FRAC_W);
            last_err_reg <= '0;
            accum_reg <= '0;
        end else begin
            state_reg <= state_next;
            m_valid_reg <= m_valid_next;
            if (state_reg == ST_OUT && out_free) begin
                last_err_reg <= err_reg;
                accum_reg <= acc_reg;
            end
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_GAIN_P:    gain_p_reg <= cfg_data;
                    REG_GAIN_I:    gain_i_reg <= cfg_data;
                    REG_GAIN_D:    gain_d_reg <= cfg_data;
                    REG_TOLERANCE: tol_reg <= cfg_data[TOL_W-1:0];
                    REG_DRIVE_MIN: drive_min_reg <= cfg_data;
                    REG_DRIVE_MAX: drive_max_reg <= cfg_data;
                    REG_ACCUM_MIN: accum_min_reg <= cfg_data;
                    REG_ACCUM_MAX: accum_max_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_drive = m_drive_reg;
    assign m_reached = m_reached_reg;
    assign m_accum_now = m_acc_reg;
    assign m_error_now = m_err_reg;

    a_div_done_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_PH1))
        else $error("divider finished outside the first phase");

    a_mul_done_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (mul0_done || mul1_done) |-> (state_reg == ST_PH1 || state_reg == ST_PH2))
        else $error("multiplier finished outside a compute phase");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second item taken while one is in work");

    a_acc_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && accum_min_reg <= accum_max_reg) |->
        (acc_reg >= accum_min_reg && acc_reg <= accum_max_reg))
        else $error("integral outside its limits");

endmodule
